// ----- design/mvd_pkg.sv -----
// ----------------------------------------------------------------------------
// mvd_pkg: shared constants for the mesh vertex deduplication table
// Table depths, index and count widths, and the packing of the stream words.
// ----------------------------------------------------------------------------
`default_nettype none

package mvd_pkg;

  // Table depths.
  localparam int POSITION_DEPTH = 256;
  localparam int TEXCOORD_DEPTH = 256;

  // Index width addresses one entry; count width holds the depth itself.
  localparam int PIW = $clog2(POSITION_DEPTH);
  localparam int TIW = $clog2(TEXCOORD_DEPTH);
  localparam int PCW = $clog2(POSITION_DEPTH + 1);
  localparam int TCW = $clog2(TEXCOORD_DEPTH + 1);

  // Entry widths.
  localparam int COORD_W = 32;
  localparam int POS_W   = 3 * COORD_W;
  localparam int TEX_W   = 2 * COORD_W;

  // Stream word widths.
  localparam int IN_W  = POS_W + TEX_W;
  localparam int OUT_W = 40;

  // Result fields.
  localparam int OUT_IDX_W  = 8;
  localparam int TRI_W      = 16;
  localparam int CORNER_W   = 2;
  localparam int FULL_W     = 2;
  localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd2;
  localparam logic [TRI_W-1:0]    TRI_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [TRI_W-1:0]     triangle_number;
    logic                 triangle_done;
    logic [CORNER_W-1:0]  corner_number;
    logic [FULL_W-1:0]    table_full;
    logic                 texcoord_was_new;
    logic                 position_was_new;
    logic [OUT_IDX_W-1:0] texcoord_index;
    logic [OUT_IDX_W-1:0] position_index;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mesh_vertex_dedup_table.sv -----
// ----------------------------------------------------------------------------
// mesh_vertex_dedup_table
// Deduplicates triangle corners into a position table and a texture table.
// ----------------------------------------------------------------------------
// How the block is used:
// The slave stream (s_tvalid, s_tready, s_tdata) takes one triangle corner per
// item: pos_x, pos_y, pos_z, tex_u and tex_v packed from the lowest bit up. The
// master stream (m_tvalid, m_tready, m_tdata) returns one result item per
// corner with the position and texture indices, new-entry flags, full flags
// and the corner and triangle numbering.
// Both tables live in synchronous memories and are scanned side by side, one
// read per cycle each. A scan reads every counted entry, or stops at the first
// match, which costs one more read when another entry follows the hit. Once
// both scans end and the output register is free, the result is registered;
// the next item is taken in the cycle after that, so each item is finished
// before the next one is accepted.
// If the receiver stalls, the finished result of the next item waits in the
// insert step and no table is changed until the output register is free.
// Reset clears both entry counts, the corner counter and the triangle count;
// the memory contents need no clearing because only counted entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_vertex_dedup_table (
  input  wire                    clk,
  input  wire                    rst,
  // s_tdata fields from the lowest bit: pos_x, pos_y, pos_z, tex_u, tex_v.
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  wire [mvd_pkg::IN_W-1:0] s_tdata,
  // m_tdata fields from the lowest bit: position_index, texcoord_index,
  // position_was_new, texcoord_was_new, table_full, corner_number,
  // triangle_done, triangle_number, one pad bit.
  output logic                   m_tvalid,
  input  wire                    m_tready,
  output logic [mvd_pkg::OUT_W-1:0] m_tdata
);

  import mvd_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_INSERT} state_t;

  state_t state;

  // Search keys of the corner in progress.
  logic [POS_W-1:0] pos_key;
  logic [TEX_W-1:0] tex_key;

  // Table memories.
  logic [POS_W-1:0] pos_mem [POSITION_DEPTH];
  logic [TEX_W-1:0] tex_mem [TEXCOORD_DEPTH];
  logic [POS_W-1:0] pos_rdata;
  logic [TEX_W-1:0] tex_rdata;

  // Scan control for each table.
  logic [PCW-1:0] pos_count, pos_addr;
  logic [TCW-1:0] tex_count, tex_addr;
  logic [PIW-1:0] pos_rd_idx, pos_hit_idx;
  logic [TIW-1:0] tex_rd_idx, tex_hit_idx;
  logic           pos_rd_valid, tex_rd_valid;
  logic           pos_found, tex_found;

  logic [CORNER_W-1:0] corner_counter;
  logic [TRI_W-1:0]    triangle_count;

  logic pos_issue, tex_issue, pos_match, tex_match;
  logic pos_idle, tex_idle, out_free, fire;
  logic pos_room, tex_room;
  logic pos_we, tex_we;
  result_t res;
  logic [31:0] pos_idx_wide, tex_idx_wide;

  assign pos_issue = !pos_found && (pos_addr < pos_count);
  assign tex_issue = !tex_found && (tex_addr < tex_count);
  assign pos_match = pos_rd_valid && (pos_rdata == pos_key);
  assign tex_match = tex_rd_valid && (tex_rdata == tex_key);
  assign pos_idle  = !pos_rd_valid && (pos_found || pos_addr >= pos_count);
  assign tex_idle  = !tex_rd_valid && (tex_found || tex_addr >= tex_count);

  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == ST_INSERT) && out_free;
  assign s_tready = (state == ST_IDLE);

  assign pos_room = pos_count < PCW'(POSITION_DEPTH);
  assign tex_room = tex_count < TCW'(TEXCOORD_DEPTH);
  assign pos_we   = fire && !pos_found && pos_room;
  assign tex_we   = fire && !tex_found && tex_room;

  // Result of the corner in the insert step.
  always_comb begin
    pos_idx_wide = 32'd0;
    tex_idx_wide = 32'd0;
    res = '0;
    if (pos_found) begin
      pos_idx_wide = 32'(pos_hit_idx);
    end else if (pos_room) begin
      pos_idx_wide = 32'(pos_count);
      res.position_was_new = 1'b1;
    end else begin
      res.table_full[0] = 1'b1;
    end
    if (tex_found) begin
      tex_idx_wide = 32'(tex_hit_idx);
    end else if (tex_room) begin
      tex_idx_wide = 32'(tex_count);
      res.texcoord_was_new = 1'b1;
    end else begin
      res.table_full[1] = 1'b1;
    end
    res.position_index = pos_idx_wide[OUT_IDX_W-1:0];
    res.texcoord_index = tex_idx_wide[OUT_IDX_W-1:0];
    if (corner_counter >= LAST_CORNER) begin
      res.corner_number   = LAST_CORNER;
      res.triangle_done   = 1'b1;
      res.triangle_number = triangle_count;
    end else begin
      res.corner_number = corner_counter;
    end
  end

  // Memories: one write port used at insert, one registered read port.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_count[PIW-1:0]] <= pos_key;
    end
    pos_rdata <= pos_mem[pos_addr[PIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tex_we) begin
      tex_mem[tex_count[TIW-1:0]] <= tex_key;
    end
    tex_rdata <= tex_mem[tex_addr[TIW-1:0]];
  end

  // Control and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pos_count      <= '0;
      tex_count      <= '0;
      corner_counter <= '0;
      triangle_count <= '0;
      pos_rd_valid   <= 1'b0;
      tex_rd_valid   <= 1'b0;
      pos_found      <= 1'b0;
      tex_found      <= 1'b0;
      pos_addr       <= '0;
      tex_addr       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // A taken result empties the output register unless a new one enters.
      if (m_tvalid && m_tready && !fire) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            pos_key      <= s_tdata[POS_W-1:0];
            tex_key      <= s_tdata[IN_W-1:POS_W];
            pos_addr     <= '0;
            tex_addr     <= '0;
            pos_found    <= 1'b0;
            tex_found    <= 1'b0;
            pos_rd_valid <= 1'b0;
            tex_rd_valid <= 1'b0;
            state        <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Reads issued now return next cycle; the first hit wins.
          pos_rd_valid <= pos_issue;
          tex_rd_valid <= tex_issue;
          pos_rd_idx   <= pos_addr[PIW-1:0];
          tex_rd_idx   <= tex_addr[TIW-1:0];
          if (pos_issue) begin
            pos_addr <= pos_addr + 1'b1;
          end
          if (tex_issue) begin
            tex_addr <= tex_addr + 1'b1;
          end
          if (pos_match && !pos_found) begin
            pos_found   <= 1'b1;
            pos_hit_idx <= pos_rd_idx;
          end
          if (tex_match && !tex_found) begin
            tex_found   <= 1'b1;
            tex_hit_idx <= tex_rd_idx;
          end
          if (pos_idle && tex_idle) begin
            state <= ST_INSERT;
          end
        end
        ST_INSERT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'(res);
            if (pos_we) begin
              pos_count <= pos_count + 1'b1;
            end
            if (tex_we) begin
              tex_count <= tex_count + 1'b1;
            end
            if (corner_counter >= LAST_CORNER) begin
              corner_counter <= '0;
              if (triangle_count != TRI_MAX) begin
                triangle_count <= triangle_count + 1'b1;
              end
            end else begin
              corner_counter <= corner_counter + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/mvd_checker.sv -----
// ----------------------------------------------------------------------------
// mvd_checker: port-level checks for the mesh vertex deduplication table
// Watches the streams and the packed result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module mvd_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tvalid,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [mvd_pkg::OUT_W-1:0]  m_tdata
);

  import mvd_pkg::*;

  result_t res;
  assign res = result_t'(m_tdata[$bits(result_t)-1:0]);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One corner at a time: no item is taken right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken during a search");

  // A finished triangle is always the third corner.
  a_done_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.triangle_done |-> res.corner_number == LAST_CORNER)
    else $error("triangle done on wrong corner");

  // No triangle number unless a triangle is finished.
  a_tri_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !res.triangle_done |-> res.triangle_number == '0)
    else $error("triangle number without triangle");

  // A full position miss inserts nothing and reports index zero.
  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.table_full[0] |-> !res.position_was_new && res.position_index == '0)
    else $error("position full miss reported an entry");

endmodule

bind mesh_vertex_dedup_table mvd_checker u_mvd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
